// ===== src/psoc_pkg.sv =====
`timescale 1ns / 1ps
package psoc_pkg;

  // Register map of the configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_FORMAT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ALPHA = 1'd1;

  // Operation codes
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_TFILL = 2'd1;
  localparam logic [1:0] OP_COPY  = 2'd2;

  // Framebuffer formats
  localparam logic [1:0] FMT_ARGB8888 = 2'd0;
  localparam logic [1:0] FMT_RGB888   = 2'd1;
  localparam logic [1:0] FMT_RGB565   = 2'd2;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [31:0] ALPHA_FORCE  = 32'hFF00_0000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // What the back end does with an item
  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_DIRECT,
    KIND_BLEND
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  alpha;
    logic [23:0] color;
    logic [23:0] dst;
  } item_t;

  // Rounded divide by 255 of a product of two bytes
  function automatic logic [7:0] d255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, x} + 17'd128;
    u = t + {9'd0, t[15:8]};
    return u[15:8];
  endfunction

  // Raw destination to 8 bits per channel
  function automatic logic [23:0] expand_dst(input logic [1:0] fmt, input logic [23:0] raw);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = raw[15:11];
    g = raw[10:5];
    b = raw[4:0];
    if (fmt == FMT_RGB565) begin
      return {r, r[4:2], g, g[5:4], b, b[4:2]};
    end
    return raw;
  endfunction

  // 8 bits per channel to raw framebuffer pixel
  function automatic logic [31:0] pack_out(input logic [1:0] fmt, input logic [23:0] rgb);
    logic [31:0] pix;
    unique case (fmt)
      FMT_RGB565: pix = {16'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
      FMT_RGB888: pix = {8'd0, rgb};
      default:    pix = ALPHA_FORCE | {8'd0, rgb};
    endcase
    return pix;
  endfunction

endpackage

// ===== src/psoc_queue.sv =====
`timescale 1ns / 1ps
module psoc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  psoc_pkg::item_t        push_item,
  input  logic                   pop,
  output psoc_pkg::item_t        head_item,
  output logic                   not_empty,
  output logic [psoc_pkg::QCNT_W-1:0] count
);
  import psoc_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head_item = mem[rd_ptr];
  assign not_empty = (count != '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == '0))
    else $error("queue read while empty");

endmodule

// ===== src/psoc_front.sv =====
`timescale 1ns / 1ps
module psoc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  global_alpha,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [31:0]                 src_pixel,
  input  logic [31:0]                 dst_pixel,
  input  logic [psoc_pkg::QCNT_W-1:0] q_count,
  output logic                        push,
  output psoc_pkg::item_t             push_item
);
  import psoc_pkg::*;

  logic        accept;
  logic [7:0]  scale;
  logic [QCNT_W-1:0] occupancy;

  // stage 1: products
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [31:0] s1_src;
  logic [23:0] s1_dst;
  logic [15:0] s1_pa;
  logic [15:0] s1_pr;
  logic [15:0] s1_pg;
  logic [15:0] s1_pb;

  // stage 2: classified item
  logic        s2_valid;
  item_t       s2_item;
  item_t       s2_next;
  logic [7:0]  alpha_scaled;
  logic [23:0] color_scaled;

  // Items in flight plus queued ones never exceed the queue depth
  assign occupancy = q_count + QCNT_W'(s1_valid) + QCNT_W'(s2_valid);
  assign in_stall  = rst || (occupancy >= QCNT_W'(QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;

  // Copy scales by the global alpha, translucent fill by its own alpha
  assign scale = (req_type == OP_COPY) ? global_alpha : src_pixel[31:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_op  <= req_type;
      s1_src <= src_pixel;
      s1_dst <= dst_pixel[23:0];
      s1_pa  <= src_pixel[31:24] * scale;
      s1_pr  <= src_pixel[23:16] * scale;
      s1_pg  <= src_pixel[15:8]  * scale;
      s1_pb  <= src_pixel[7:0]   * scale;
    end
  end

  // Divide down and classify
  assign alpha_scaled = d255(s1_pa);
  assign color_scaled = {d255(s1_pr), d255(s1_pg), d255(s1_pb)};

  always_comb begin
    s2_next.dst   = s1_dst;
    s2_next.alpha = s1_src[31:24];
    s2_next.color = color_scaled;
    s2_next.kind  = KIND_SKIP;
    unique case (s1_op)
      OP_FILL: begin
        s2_next.kind  = KIND_DIRECT;
        s2_next.color = s1_src[23:0];
      end
      OP_TFILL: begin
        s2_next.kind = (s1_src[31:24] != 8'd0) ? KIND_BLEND : KIND_SKIP;
      end
      OP_COPY: begin
        s2_next.alpha = alpha_scaled;
        if (alpha_scaled == ALPHA_OPAQUE) begin
          s2_next.kind = KIND_DIRECT;
        end else if (alpha_scaled != 8'd0) begin
          s2_next.kind = KIND_BLEND;
        end
      end
      default: s2_next.kind = KIND_SKIP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_item <= s2_next;
    end
  end

  assign push      = s2_valid;
  assign push_item = s2_item;

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= QCNT_W'(QUEUE_DEPTH))
    else $error("front end has more items than queue space");

endmodule

// ===== src/psoc_back.sv =====
`timescale 1ns / 1ps
module psoc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      fb_format,
  input  psoc_pkg::item_t head_item,
  input  logic            not_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            write_enable,
  output logic [31:0]     out_pixel
);
  import psoc_pkg::*;

  logic        out_adv;
  logic        c_load;
  logic [23:0] dst_rgb;
  logic [7:0]  inv;

  // stage C: destination products
  logic        c_valid;
  kind_t       c_kind;
  logic [23:0] c_color;
  logic [15:0] c_pr;
  logic [15:0] c_pg;
  logic [15:0] c_pb;

  logic [8:0]  sum_r;
  logic [8:0]  sum_g;
  logic [8:0]  sum_b;
  logic [23:0] mix;
  logic [23:0] rgb;

  // Back pressure from the output register
  assign out_adv = !out_valid || !out_stall;
  assign c_load  = !c_valid || out_adv;
  assign pop     = not_empty && c_load;

  assign dst_rgb = expand_dst(fb_format, head_item.dst);
  assign inv     = ALPHA_OPAQUE - head_item.alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_load) begin
      c_valid <= not_empty;
    end
    if (pop) begin
      c_kind  <= head_item.kind;
      c_color <= head_item.color;
      c_pr    <= dst_rgb[23:16] * inv;
      c_pg    <= dst_rgb[15:8]  * inv;
      c_pb    <= dst_rgb[7:0]   * inv;
    end
  end

  // Source plus scaled destination, saturated per channel
  assign sum_r = {1'b0, c_color[23:16]} + {1'b0, d255(c_pr)};
  assign sum_g = {1'b0, c_color[15:8]}  + {1'b0, d255(c_pg)};
  assign sum_b = {1'b0, c_color[7:0]}   + {1'b0, d255(c_pb)};
  assign mix   = {sum_r[8] ? 8'hFF : sum_r[7:0],
                  sum_g[8] ? 8'hFF : sum_g[7:0],
                  sum_b[8] ? 8'hFF : sum_b[7:0]};
  assign rgb   = (c_kind == KIND_BLEND) ? mix : c_color;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= c_valid;
    end
    if (out_adv && c_valid) begin
      write_enable <= (c_kind != KIND_SKIP);
      out_pixel    <= (c_kind == KIND_SKIP) ? 32'd0 : pack_out(fb_format, rgb);
    end
  end

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> out_pixel == 32'd0)
    else $error("skipped pixel carries data");

endmodule

// ===== src/pixel_source_over_compositor.sv =====
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// in       in_valid/in_stall   req_type, src_pixel, dst_pixel
// out      out_valid/out_stall write_enable, out_pixel
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall stays low.
// A beat passes two front stages (scale multiply, divide and classify), the
// queue, and two back stages (destination multiply, blend and pack).
// Reset (rst, synchronous) empties the pipeline and queue; fb_format returns to
// ARGB8888 and global_alpha to 255. in_stall and cfg_ready are held during reset.
// in_stall rises once beats in the two front stages plus queued beats reach four.
module pixel_source_over_compositor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [31:0]                    src_pixel,
  input  logic [31:0]                    dst_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           write_enable,
  output logic [31:0]                    out_pixel
);
  import psoc_pkg::*;

  logic [1:0]        fb_format;
  logic [7:0]        global_alpha;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             head_item;
  logic              not_empty;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_format    <= FMT_ARGB8888;
      global_alpha <= ALPHA_OPAQUE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FB_FORMAT:    fb_format    <= cfg_data[1:0];
        REG_GLOBAL_ALPHA: global_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  psoc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .global_alpha (global_alpha),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .src_pixel    (src_pixel),
    .dst_pixel    (dst_pixel),
    .q_count      (q_count),
    .push         (push),
    .push_item    (push_item)
  );

  psoc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (not_empty),
    .count     (q_count)
  );

  psoc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fb_format    (fb_format),
    .head_item    (head_item),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .out_pixel    (out_pixel)
  );

endmodule
